// ===== design/hexmix_pkg.sv =====
// Shared types and constants for the hexacopter motor mixer with safety cut-off.
// Depends on nothing; every other design file imports it.
package hexmix_pkg;

	localparam int NUM_MOTORS = 6;
	localparam int CMD_W      = 11;   // motor command and throttle width
	localparam int TERM_W     = 16;   // controller terms and angles
	localparam int TILT_W     = 15;
	localparam int ANG_MAG_W  = TERM_W + 1;
	localparam int SUM_W      = 28;   // holds any weighted sum in thousandths
	localparam int MAG_W      = 27;   // magnitude of a weighted sum
	localparam int DIVA_W     = MAG_W - 3; // magnitude after the divide by eight
	localparam int RECIP_W    = 25;
	localparam int RECIP_SH   = 31;
	localparam int PROD_W     = DIVA_W + RECIP_W;
	localparam int QUO_W      = PROD_W - RECIP_SH;
	localparam int EXC_W      = 16;   // desaturation excess, never above 32767
	localparam int CLAMP_W    = 18;   // command after excess is taken off
	localparam int IN_W       = 104;
	localparam int OUT_W      = 72;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int NUM_STAGES = 8;

	// Divide by 125 of a 24-bit value: floor(a * ceil(2^31 / 125) / 2^31)
	localparam logic [RECIP_W-1:0] RECIP_125 = 25'd17179870;

	// Mixer weights in thousandths; side motors use twice the roll weight
	localparam logic signed [SUM_W-1:0] W_THR   = 28'sd1000;
	localparam logic signed [SUM_W-1:0] W_ROLL  = 28'sd500;
	localparam logic signed [SUM_W-1:0] W_PITCH = 28'sd866;
	localparam logic signed [SUM_W-1:0] W_YAW   = 28'sd1000;

	localparam logic [TERM_W-1:0] MOTOR_MAX = 16'h7fff;
	localparam logic [TERM_W-1:0] MOTOR_MIN = 16'h8000;

	// Register reset values
	localparam logic [CMD_W-1:0]  RST_MAX_THR   = 11'd1900;
	localparam logic [CMD_W-1:0]  RST_MIN_THR   = 11'd1100;
	localparam logic [CMD_W-1:0]  RST_MIN_CHECK = 11'd1150;
	localparam logic [CMD_W-1:0]  RST_IDLE_CMD  = 11'd1000;
	localparam logic [TILT_W-1:0] RST_TILT_LIM  = 15'd6000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_THR   = 3'd0,
		REG_MIN_THR   = 3'd1,
		REG_MIN_CHECK = 3'd2,
		REG_IDLE_CMD  = 3'd3,
		REG_TILT_LIM  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CMD_W-1:0]  max_thr;
		logic [CMD_W-1:0]  min_thr;
		logic [CMD_W-1:0]  min_check;
		logic [CMD_W-1:0]  idle_cmd;
		logic [TILT_W-1:0] tilt_lim;
	} cfg_t;

	// Input item, last field in the lowest bits
	typedef struct packed {
		logic signed [TERM_W-1:0] pitch_angle;
		logic signed [TERM_W-1:0] roll_angle;
		logic [CMD_W-1:0]         stick_throttle;
		logic                     alt_hold_on;
		logic                     is_armed;
		logic signed [TERM_W-1:0] yaw_term;
		logic signed [TERM_W-1:0] pitch_term;
		logic signed [TERM_W-1:0] roll_term;
		logic [CMD_W-1:0]         base_throttle;
	} in_item_t;

	// Safety state that rides alongside the motor data
	typedef struct packed {
		logic idle;
		logic tilt;
	} flag_t;

	// Per-stage load enables, stage 1 in the lowest bit
	typedef struct packed {
		logic s8;
		logic s7;
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} pipe_en_t;

	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [TERM_W-1:0] motor_t;
	typedef logic [CMD_W-1:0]         cmd_t;
	typedef sum_t   [NUM_MOTORS-1:0]  sum_arr_t;
	typedef motor_t [NUM_MOTORS-1:0]  motor_arr_t;
	typedef cmd_t   [NUM_MOTORS-1:0]  cmd_arr_t;

endpackage

// ===== design/hexmix_cfg.sv =====
// Configuration register file of the hexacopter mixer.
// Depends on hexmix_pkg for the register index codes and reset values.
module hexmix_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hexmix_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hexmix_pkg::CFG_DATA_W-1:0]   cfg_data,
	output hexmix_pkg::cfg_t                    cfg
);
	import hexmix_pkg::*;

	cfg_t cfg_q;

	// Always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_thr   <= RST_MAX_THR;
			cfg_q.min_thr   <= RST_MIN_THR;
			cfg_q.min_check <= RST_MIN_CHECK;
			cfg_q.idle_cmd  <= RST_IDLE_CMD;
			cfg_q.tilt_lim  <= RST_TILT_LIM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_MAX_THR:   cfg_q.max_thr   <= cfg_data[CMD_W-1:0];
				REG_MIN_THR:   cfg_q.min_thr   <= cfg_data[CMD_W-1:0];
				REG_MIN_CHECK: cfg_q.min_check <= cfg_data[CMD_W-1:0];
				REG_IDLE_CMD:  cfg_q.idle_cmd  <= cfg_data[CMD_W-1:0];
				REG_TILT_LIM:  cfg_q.tilt_lim  <= cfg_data[TILT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/hexmix_sum.sv =====
// Input register, weighted products and the six motor sums (stages 1 to 3).
// Also derives the tilt and forced-idle flags. Depends on hexmix_pkg.
module hexmix_sum (
	input  logic                  clk,
	input  hexmix_pkg::pipe_en_t  en,
	input  hexmix_pkg::in_item_t  item,
	input  hexmix_pkg::cfg_t      cfg,
	output hexmix_pkg::sum_arr_t  sum_s3,
	output hexmix_pkg::flag_t     flag_s3
);
	import hexmix_pkg::*;

	in_item_t              item_s1;
	sum_t                  p_thr_s2, p_roll_s2, p_pitch_s2, p_yaw_s2;
	flag_t                 flag_s2;
	flag_t                 flag_c;
	logic [ANG_MAG_W-1:0]  ra_mag, pa_mag;
	logic signed [ANG_MAG_W-1:0] ra_x, pa_x;
	sum_t                  r1, r2, sum_c0, sum_c1, sum_c2, sum_c3, sum_c4, sum_c5;

	// Stage 1: capture the transaction
	always_ff @(posedge clk) begin
		if (en.s1) begin
			item_s1 <= item;
		end
	end

	// Tilt check on exact angle magnitudes, then the forced-idle decision
	always_comb begin
		ra_x   = ANG_MAG_W'(item_s1.roll_angle);
		pa_x   = ANG_MAG_W'(item_s1.pitch_angle);
		ra_mag = ra_x[ANG_MAG_W-1] ? ANG_MAG_W'(-ra_x) : ANG_MAG_W'(ra_x);
		pa_mag = pa_x[ANG_MAG_W-1] ? ANG_MAG_W'(-pa_x) : ANG_MAG_W'(pa_x);
		flag_c.tilt = (ra_mag > ANG_MAG_W'(cfg.tilt_lim)) ||
			(pa_mag > ANG_MAG_W'(cfg.tilt_lim));
		flag_c.idle = !item_s1.is_armed ||
			(!item_s1.alt_hold_on && (item_s1.stick_throttle < cfg.min_check)) ||
			flag_c.tilt;
	end

	// Stage 2: constant-weight products, shared by all motors
	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_thr_s2   <= sum_t'({1'b0, item_s1.base_throttle}) * W_THR;
			p_roll_s2  <= sum_t'(item_s1.roll_term) * W_ROLL;
			p_pitch_s2 <= sum_t'(item_s1.pitch_term) * W_PITCH;
			p_yaw_s2   <= sum_t'(item_s1.yaw_term) * W_YAW;
			flag_s2    <= flag_c;
		end
	end

	// Motor sums with their sign patterns
	always_comb begin
		r1 = p_roll_s2;
		r2 = p_roll_s2 <<< 1;
		sum_c0 = p_thr_s2 + r1 + p_pitch_s2 - p_yaw_s2;
		sum_c1 = p_thr_s2 - r1 - p_pitch_s2 + p_yaw_s2;
		sum_c2 = p_thr_s2 - r1 + p_pitch_s2 + p_yaw_s2;
		sum_c3 = p_thr_s2 + r1 - p_pitch_s2 - p_yaw_s2;
		sum_c4 = p_thr_s2 + r2 + p_yaw_s2;
		sum_c5 = p_thr_s2 - r2 - p_yaw_s2;
	end

	// Stage 3
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_s3  <= {sum_c5, sum_c4, sum_c3, sum_c2, sum_c1, sum_c0};
			flag_s3 <= flag_s2;
		end
	end

endmodule

// ===== design/hexmix_div.sv =====
// Divide of each motor sum by 1000, truncated toward zero, and 16-bit saturation
// (stages 4 to 6). Reciprocal multiply on the magnitude. Depends on hexmix_pkg.
module hexmix_div (
	input  logic                    clk,
	input  hexmix_pkg::pipe_en_t    en,
	input  hexmix_pkg::sum_arr_t    sum_s3,
	input  hexmix_pkg::flag_t       flag_s3,
	output hexmix_pkg::motor_arr_t  mot_s6,
	output hexmix_pkg::flag_t       flag_s6
);
	import hexmix_pkg::*;

	flag_t flag_s4, flag_s5;

	// Safety flags follow the lanes
	always_ff @(posedge clk) begin
		if (en.s4) flag_s4 <= flag_s3;
		if (en.s5) flag_s5 <= flag_s4;
		if (en.s6) flag_s6 <= flag_s5;
	end

	for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_lane
		logic                neg_s4, neg_s5;
		logic [DIVA_W-1:0]   a_s4;
		logic [QUO_W-1:0]    q_s5;
		sum_t                sv;
		sum_t                mag;
		logic [PROD_W-1:0]   prod;
		motor_t              m_c;

		// Stage 4: magnitude, already divided by eight
		always_comb begin
			sv  = sum_s3[i];
			mag = sv[SUM_W-1] ? -sv : sv;
		end

		always_ff @(posedge clk) begin
			if (en.s4) begin
				neg_s4 <= sv[SUM_W-1];
				a_s4   <= mag[MAG_W-1:3];
			end
		end

		// Stage 5: divide by 125 through the reciprocal
		assign prod = PROD_W'(a_s4) * PROD_W'(RECIP_125);

		always_ff @(posedge clk) begin
			if (en.s5) begin
				neg_s5 <= neg_s4;
				q_s5   <= prod[PROD_W-1:RECIP_SH];
			end
		end

		// Stage 6: restore sign and saturate to 16 bits
		always_comb begin
			if (neg_s5) begin
				if (q_s5 > QUO_W'(MOTOR_MIN)) m_c = MOTOR_MIN;
				else m_c = TERM_W'(-q_s5);
			end else begin
				if (q_s5 > QUO_W'(MOTOR_MAX)) m_c = MOTOR_MAX;
				else m_c = q_s5[TERM_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en.s6) begin
				mot_s6[i] <= m_c;
			end
		end
	end

endmodule

// ===== design/hexmix_limit.sv =====
// Desaturation against max_throttle, clamp, forced idle and output register
// (stages 7 and 8). Depends on hexmix_pkg.
module hexmix_limit (
	input  logic                    clk,
	input  hexmix_pkg::pipe_en_t    en,
	input  hexmix_pkg::cfg_t        cfg,
	input  hexmix_pkg::motor_arr_t  mot_s6,
	input  hexmix_pkg::flag_t       flag_s6,
	output hexmix_pkg::cmd_arr_t    cmd_s8,
	output logic                    tilt_s8
);
	import hexmix_pkg::*;

	motor_t                       mot_s7 [NUM_MOTORS];
	flag_t                        flag_s7;
	logic [EXC_W-1:0]             excess_s7;
	motor_t                       mx01, mx23, mx45, mx03, top;
	logic signed [TERM_W:0]       diff;
	logic [EXC_W-1:0]             excess_c;
	logic signed [CLAMP_W-1:0]    lo_x, hi_x;

	// Largest command through a three-level compare tree
	always_comb begin
		mx01 = (mot_s6[1] > mot_s6[0]) ? mot_s6[1] : mot_s6[0];
		mx23 = (mot_s6[3] > mot_s6[2]) ? mot_s6[3] : mot_s6[2];
		mx45 = (mot_s6[5] > mot_s6[4]) ? mot_s6[5] : mot_s6[4];
		mx03 = (mx23 > mx01) ? mx23 : mx01;
		top  = (mx45 > mx03) ? mx45 : mx03;
		diff = (TERM_W+1)'(top) - $signed({6'b0, cfg.max_thr});
		excess_c = (diff > 0) ? diff[EXC_W-1:0] : '0;
	end

	// Stage 7
	always_ff @(posedge clk) begin
		if (en.s7) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				mot_s7[i] <= mot_s6[i];
			end
			excess_s7 <= excess_c;
			flag_s7   <= flag_s6;
		end
	end

	assign lo_x = $signed({7'b0, cfg.min_thr});
	assign hi_x = $signed({7'b0, cfg.max_thr});

	// Stage 8: take off the excess, clamp (lower limit first), idle override
	for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_out
		logic signed [CLAMP_W-1:0] v;
		cmd_t                      c;

		always_comb begin
			v = CLAMP_W'(mot_s7[i]) - $signed({2'b0, excess_s7});
			if (v < lo_x) c = cfg.min_thr;
			else if (v > hi_x) c = cfg.max_thr;
			else c = v[CMD_W-1:0];
		end

		always_ff @(posedge clk) begin
			if (en.s8) begin
				cmd_s8[i] <= flag_s7.idle ? cfg.idle_cmd : c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s8) begin
			tilt_s8 <= flag_s7.tilt;
		end
	end

endmodule

// ===== design/hex_motor_mixer_with_safety_unit.sv =====
// Top level of the hexacopter X motor mixer with safety cut-off.
// Depends on hexmix_pkg, hexmix_cfg, hexmix_sum, hexmix_div and hexmix_limit.
//
// Usage:
//  - Input stream s_*: one transaction per control update carrying throttle,
//    roll/pitch/yaw terms, arming state, altitude hold, stick throttle and angles.
//  - Output stream m_*: one transaction per input with six motor commands and
//    the tilt disarm flag.
//  - Config channel cfg_*: register writes, always ready; write only while the
//    pipeline is empty. Unknown indexes are ignored.
//  - There are eight register stages, the input register loaded at the accepting
//    edge. Throughput is one transaction per cycle while m_tready is high: an
//    eight-stage pipeline, whose longest step is the 24x25 reciprocal multiply of
//    the divide by 1000.
//  - Each stage holds its item until the next stage frees up, so a stalled
//    receiver fills the pipeline from the output end; s_tready falls only once
//    all eight stages hold items, and no transaction is lost or repeated.
//  - Reset clears the stage valid bits and loads the register reset values
//    (max 1900, min 1100, min check 1150, idle 1000, tilt limit 6000).
module hex_motor_mixer_with_safety_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// base_throttle, roll_term, pitch_term, yaw_term, is_armed, alt_hold_on,
	// stick_throttle, roll_angle, pitch_angle (from bit 0 up)
	input  logic [hexmix_pkg::IN_W-1:0]        s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// motor_0 .. motor_5, tilt_disarm, zero fill (from bit 0 up)
	output logic [hexmix_pkg::OUT_W-1:0]       m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hexmix_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hexmix_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import hexmix_pkg::*;

	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES+1:1] adv;
	pipe_en_t              en;
	cfg_t                  cfg;
	in_item_t              item;
	sum_arr_t              sum_s3;
	flag_t                 flag_s3, flag_s6;
	motor_arr_t            mot_s6;
	cmd_arr_t              cmd_s8;
	logic                  tilt_s8;

	// A stage loads when it is empty or its contents move on
	always_comb begin
		adv[NUM_STAGES+1] = m_tready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign en       = pipe_en_t'(adv[NUM_STAGES:1]);
	assign s_tready = adv[1];
	assign m_tvalid = vld_q[NUM_STAGES];

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign item = in_item_t'(s_tdata);

	hexmix_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hexmix_sum u_sum (
		.clk     (clk),
		.en      (en),
		.item    (item),
		.cfg     (cfg),
		.sum_s3  (sum_s3),
		.flag_s3 (flag_s3)
	);

	hexmix_div u_div (
		.clk     (clk),
		.en      (en),
		.sum_s3  (sum_s3),
		.flag_s3 (flag_s3),
		.mot_s6  (mot_s6),
		.flag_s6 (flag_s6)
	);

	hexmix_limit u_limit (
		.clk     (clk),
		.en      (en),
		.cfg     (cfg),
		.mot_s6  (mot_s6),
		.flag_s6 (flag_s6),
		.cmd_s8  (cmd_s8),
		.tilt_s8 (tilt_s8)
	);

	assign m_tdata = {5'b0, tilt_s8, cmd_s8};

	// A tilt trip forces every motor to idle; checked on motors 0 and 5
	a_tilt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[66] |->
			m_tdata[10:0] == cfg.idle_cmd && m_tdata[65:55] == cfg.idle_cmd)
		else $error("tilt trip without idle command");

	// With sane limits a motor never exceeds max_throttle unless forced idle (checked on motor 0)
	a_upper_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (cfg.min_thr <= cfg.max_thr) |->
			(m_tdata[10:0] <= cfg.max_thr) || (m_tdata[10:0] == cfg.idle_cmd))
		else $error("motor command above max_throttle");

	// An accepted transaction always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[1])
		else $error("accepted transaction lost at pipeline entry");

endmodule
